// ===== src/wrr_pkg.sv =====
// Shared constants, types and state codes for the windowed rise-ratio RSI unit.
`timescale 1ns / 1ps

package wrr_pkg;

  // Ring depth of the price history.
  localparam int DEPTH     = 64;

  localparam int PRICE_W   = 32;
  localparam int PER_W     = 7;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int CMP_W     = (PER_W > CNT_W) ? PER_W : CNT_W;
  // At most DEPTH moves of less than 2^32 each are summed.
  localparam int SUM_W     = PRICE_W + $clog2(DEPTH);
  localparam int RES_W     = 15;
  localparam int NUM_W     = SUM_W + RES_W;
  localparam int DIV_CNT_W = $clog2(RES_W + 1);

  localparam logic [PER_W-1:0] PERIOD_RST  = 7'd14;
  localparam logic [RES_W-1:0] RES_NEUTRAL = 15'd12800;
  localparam logic [RES_W-1:0] RES_MAX     = 15'd25600;

  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_SCALE,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== src/wrr_div.sv =====
// Serial restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module wrr_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [wrr_pkg::NUM_W-1:0]   dividend,
  input  logic [wrr_pkg::SUM_W-1:0]   divisor,
  output wrr_pkg::div_stat_t          stat,
  output logic [wrr_pkg::RES_W-1:0]   quotient
);
  import wrr_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0]     rem_r, rem_nxt;
  logic [SUM_W-1:0]     dvs_r, dvs_nxt;
  logic [RES_W-1:0]     quo_r, quo_nxt;
  logic [SUM_W+1:0]     trial;
  logic                 fits;

  // The caller guarantees dividend < divisor * 2^RES_W, so the upper part
  // starts below the divisor and only RES_W quotient bits are needed.
  // quo_r holds the remaining low dividend bits and fills with quotient bits.
  assign trial = {1'b0, rem_r, quo_r[RES_W-1]} - {2'b00, dvs_r};
  assign fits  = ~trial[SUM_W+1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(RES_W);
      rem_nxt  = dividend[NUM_W-1:RES_W];
      quo_nxt  = dividend[RES_W-1:0];
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? trial[SUM_W-1:0] : {rem_r[SUM_W-2:0], quo_r[RES_W-1]};
      quo_nxt = {quo_r[RES_W-2:0], fits};
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

// ===== src/windowed_rise_ratio_rsi_unit.sv =====
// Top level of the windowed rise-ratio RSI unit: history ring, sequencer, output register.
`timescale 1ns / 1ps

// An append word (func 0) stores its price in a 64-entry ring and gives no
// result. A query word (func 1) gives one result, the rise ratio times 25600,
// truncated. A query walks the history through the ring's single read port,
// one stored price per cycle, for min(period, stored prices) moves, then,
// unless the walk saw no rise or no price change, runs a divider that retires
// one quotient bit per cycle; a query with period zero or an empty history
// answers fifty. Input is stalled while a query is being worked on. The period
// register is written through the cfg port while idle.
module windowed_rise_ratio_rsi_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_func,
  input  logic [wrr_pkg::PRICE_W-1:0]   in_price,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wrr_pkg::RES_W-1:0]     out_rsi_value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wrr_pkg::PER_W-1:0]     cfg_period
);
  import wrr_pkg::*;

  logic [PRICE_W-1:0] mem [DEPTH];
  logic [PRICE_W-1:0] mem_q_r;
  logic               mem_we;

  state_t             state_r, state_nxt;
  logic [PER_W-1:0]   period_r, period_nxt;
  logic [PTR_W-1:0]   wp_r, wp_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   iss_r, iss_nxt;
  logic [CNT_W-1:0]   acc_r, acc_nxt;
  logic               q_vld_r, q_vld_nxt;
  logic [PRICE_W-1:0] prev_r, prev_nxt;
  logic [SUM_W-1:0]   rise_r, rise_nxt;
  logic [SUM_W-1:0]   tot_r, tot_nxt;
  logic [RES_W-1:0]   res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [RES_W-1:0]   out_value_r, out_value_nxt;

  logic               in_acc;
  logic [PTR_W-1:0]   newest;
  logic [CNT_W-1:0]   moves;
  logic               up;
  logic [PRICE_W-1:0] diff;
  logic [NUM_W-1:0]   num;
  logic               div_start;
  div_stat_t          div_stat;
  logic [RES_W-1:0]   div_quo;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign in_acc    = in_valid && !in_stall;

  assign newest = (wp_r == '0) ? PTR_W'(DEPTH - 1) : wp_r - PTR_W'(1);
  assign moves  = (CMP_W'(period_r) >= CMP_W'(cnt_r)) ? cnt_r : CNT_W'(period_r);

  // One move between the previous (newer) price and the one just read.
  assign up   = prev_r > mem_q_r;
  assign diff = up ? prev_r - mem_q_r : mem_q_r - prev_r;

  // 25600 = 2^14 + 2^13 + 2^10.
  assign num = (NUM_W'(rise_r) << 14) + (NUM_W'(rise_r) << 13) + (NUM_W'(rise_r) << 10);

  always_comb begin
    state_nxt     = state_r;
    period_nxt    = period_r;
    wp_nxt        = wp_r;
    cnt_nxt       = cnt_r;
    rd_ptr_nxt    = rd_ptr_r;
    iss_nxt       = iss_r;
    acc_nxt       = acc_r;
    q_vld_nxt     = 1'b0;
    prev_nxt      = prev_r;
    rise_nxt      = rise_r;
    tot_nxt       = tot_r;
    res_nxt       = res_r;
    out_value_nxt = out_value_r;
    out_valid_nxt = out_valid_r;
    mem_we        = 1'b0;
    div_start     = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_valid && cfg_ready) begin
      period_nxt = cfg_period;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_func == FUNC_APPEND) begin
            mem_we = 1'b1;
            wp_nxt = (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
            if (cnt_r < CNT_W'(DEPTH)) begin
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end else if (period_r == '0 || cnt_r == '0) begin
            res_nxt   = RES_NEUTRAL;
            state_nxt = S_DONE;
          end else begin
            rd_ptr_nxt = newest;
            iss_nxt    = moves;
            acc_nxt    = moves;
            prev_nxt   = in_price;
            rise_nxt   = '0;
            tot_nxt    = '0;
            state_nxt  = S_WALK;
          end
        end
      end
      S_WALK: begin
        // Each read is issued in the cycle before its price is accumulated.
        if (iss_r != '0) begin
          q_vld_nxt  = 1'b1;
          iss_nxt    = iss_r - CNT_W'(1);
          rd_ptr_nxt = (rd_ptr_r == '0) ? PTR_W'(DEPTH - 1) : rd_ptr_r - PTR_W'(1);
        end
        if (q_vld_r) begin
          rise_nxt = rise_r + (up ? SUM_W'(diff) : '0);
          tot_nxt  = tot_r + SUM_W'(diff);
          prev_nxt = mem_q_r;
          acc_nxt  = acc_r - CNT_W'(1);
          if (acc_r == CNT_W'(1)) begin
            state_nxt = S_SCALE;
          end
        end
      end
      S_SCALE: begin
        if (rise_r == '0 || tot_r == '0) begin
          res_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          res_nxt   = div_quo;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      period_r    <= PERIOD_RST;
      wp_r        <= '0;
      cnt_r       <= '0;
      iss_r       <= '0;
      acc_r       <= '0;
      q_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      period_r    <= period_nxt;
      wp_r        <= wp_nxt;
      cnt_r       <= cnt_nxt;
      iss_r       <= iss_nxt;
      acc_r       <= acc_nxt;
      q_vld_r     <= q_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_ptr_r    <= rd_ptr_nxt;
    prev_r      <= prev_nxt;
    rise_r      <= rise_nxt;
    tot_r       <= tot_nxt;
    res_r       <= res_nxt;
    out_value_r <= out_value_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp_r] <= in_price;
    end
    mem_q_r <= mem[rd_ptr_r];
  end

  wrr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (num),
    .divisor  (tot_r),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  assign out_valid     = out_valid_r;
  assign out_rsi_value = out_value_r;

`ifndef ASSERT_OFF
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result word appeared without a finished query");

  a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_value_r <= RES_MAX))
    else $error("result word exceeds one hundred");

  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("stored count above ring depth");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (tot_r != '0 && !div_stat.busy))
    else $error("divider started with zero divisor or while busy");

  a_walk_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (acc_r != '0 && iss_r <= acc_r))
    else $error("history walk lost track of its moves");
`endif

endmodule
